// ===== sv/rhht_pkg.sv =====
// Package for the Robin Hood hash table unit: request and status codes.
// Used by the hash table unit and the testbench; depends on nothing.
package rhht_pkg;

    typedef enum logic [1:0] {
        REQ_GET    = 2'd0,
        REQ_SET    = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DELETED   = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    localparam int unsigned GROW_LIMIT_BITS = 7;
    localparam logic [GROW_LIMIT_BITS-1:0] GROW_LIMIT_RESET = 7'd48;

endpackage

// ===== sv/rhht_mem.sv =====
// Bucket store of the Robin Hood hash table: one write port, one registered read port.
// Holds distance, hash, key and value per bucket; depends on nothing.
module rhht_mem #(
    parameter int unsigned BUCKETS    = 64,
    parameter int unsigned DIST_BITS  = 7,
    parameter int unsigned HASH_BITS  = 32,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(BUCKETS)-1:0] i_waddr,
    input  logic [DIST_BITS-1:0]       i_wdist,
    input  logic [HASH_BITS-1:0]       i_whash,
    input  logic [KEY_BITS-1:0]        i_wkey,
    input  logic [VALUE_BITS-1:0]      i_wvalue,
    input  logic [$clog2(BUCKETS)-1:0] i_raddr,
    output logic [DIST_BITS-1:0]       o_rdist,
    output logic [HASH_BITS-1:0]       o_rhash,
    output logic [KEY_BITS-1:0]        o_rkey,
    output logic [VALUE_BITS-1:0]      o_rvalue
);
    localparam int unsigned W = DIST_BITS + HASH_BITS + KEY_BITS + VALUE_BITS;
    logic [W-1:0] r_mem [BUCKETS];
    logic [W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wvalue, i_wkey, i_whash, i_wdist};
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rdist  = r_rd[DIST_BITS-1:0];
    assign o_rhash  = r_rd[DIST_BITS +: HASH_BITS];
    assign o_rkey   = r_rd[DIST_BITS+HASH_BITS +: KEY_BITS];
    assign o_rvalue = r_rd[DIST_BITS+HASH_BITS+KEY_BITS +: VALUE_BITS];
endmodule

// ===== sv/robin_hood_hash_table_unit.sv =====
// Robin Hood hash table unit with backward-shift delete. A request is taken only when the
// unit is idle and its result word is free; it then walks the probe chain one bucket at a
// time (memory read state, then compare and write state) through a bucket store with one
// write port and one registered read port. A set that inserts then walks again from the
// home bucket to the first empty bucket, and a delete then examines the following buckets,
// one more than the entries it shifts. Bucket distances are cleared by a sweep of all
// buckets after reset and on every clear request, during which no request is taken.
// Depends on rhht_pkg and rhht_mem.
module robin_hood_hash_table_unit
    import rhht_pkg::*;
#(
    parameter int unsigned BUCKETS    = 64,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 32,
    parameter int unsigned HASH_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // key[31:0], key_hash[63:32], value[95:64]
    input  logic [KEY_BITS+HASH_BITS+VALUE_BITS-1:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], value_out[34:3], padded to whole bytes
    output logic [((3+VALUE_BITS+7)/8)*8-1:0] m_axis_tdata
);
    localparam int unsigned AW = $clog2(BUCKETS);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned DW = AW + 1;
    localparam int unsigned OW = ((3 + VALUE_BITS + 7) / 8) * 8;

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_FRD, S_FCMP, S_DECIDE, S_IRD, S_ICMP, S_DRD, S_DCMP, S_DONE
    } t_state;

    t_state                r_state;
    logic [GROW_LIMIT_BITS-1:0] r_limit;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_idx, r_hole;
    logic [CW-1:0]         r_n;
    t_req                  r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [HASH_BITS-1:0]  r_hash;
    logic [VALUE_BITS-1:0] r_val, r_newval;
    logic [DW-1:0]         r_dist;
    logic                  r_found;
    logic [AW-1:0]         r_fidx;
    logic [VALUE_BITS-1:0] r_fval;
    logic                  r_ovalid;
    logic [2:0]            r_ostatus;
    logic [VALUE_BITS-1:0] r_ovalue;

    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [DW-1:0]         wdist, rdist;
    logic [HASH_BITS-1:0]  whash, rhash;
    logic [KEY_BITS-1:0]   wkey, rkey;
    logic [VALUE_BITS-1:0] wvalue, rvalue;

    rhht_mem #(.BUCKETS(BUCKETS), .DIST_BITS(DW), .HASH_BITS(HASH_BITS),
               .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdist(wdist), .i_whash(whash),
        .i_wkey(wkey), .i_wvalue(wvalue), .i_raddr(raddr), .o_rdist(rdist),
        .o_rhash(rhash), .o_rkey(rkey), .o_rvalue(rvalue)
    );

    logic accept;
    logic [AW-1:0] nxt;
    logic [CW-1:0] lim_ext;
    logic del_end;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign nxt = r_idx + 1'b1;
    assign lim_ext = CW'(r_limit);
    // The shift stops at an empty or home entry, or after the whole table has been walked.
    assign del_end = (rdist <= DW'(1)) || (r_n == CW'(BUCKETS - 1));
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = OW'({r_ovalue, r_ostatus});
    assign raddr = r_idx;

    // Write port: the sweep zeroes distances; decide and compare states store entries.
    always_comb begin
        we = 1'b0;
        waddr = r_idx;
        wdist = r_dist;
        whash = r_hash;
        wkey = r_key;
        wvalue = r_val;
        case (r_state)
            S_SWEEP: begin
                we = 1'b1;
                wdist = '0;
            end
            S_DECIDE: begin
                if (r_found && r_op == REQ_SET) begin
                    we = 1'b1;
                    waddr = r_fidx;
                    wdist = rdist;
                    whash = rhash;
                    wkey = rkey;
                    wvalue = r_newval;
                end
            end
            S_ICMP: begin
                we = (rdist == '0) || (rdist < r_dist);
            end
            S_DCMP: begin
                we = 1'b1;
                waddr = r_hole;
                if (del_end) begin
                    wdist = '0;
                end else begin
                    wdist = rdist - 1'b1;
                    whash = rhash;
                    wkey = rkey;
                    wvalue = rvalue;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_idx <= '0;
            r_limit <= GROW_LIMIT_RESET;
            r_count <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_SWEEP: begin
                    r_idx <= nxt;
                    if (r_idx == AW'(BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op <= t_req'(s_axis_tuser);
                        r_key <= s_axis_tdata[KEY_BITS-1:0];
                        r_hash <= s_axis_tdata[KEY_BITS +: HASH_BITS];
                        r_newval <= s_axis_tdata[KEY_BITS+HASH_BITS +: VALUE_BITS];
                        r_n <= '0;
                        r_found <= 1'b0;
                        if (t_req'(s_axis_tuser) == REQ_CLEAR) begin
                            r_count <= '0;
                            r_idx <= '0;
                            r_ostatus <= ST_DELETED;
                            r_ovalue <= '0;
                            r_ovalid <= 1'b1;
                            r_state <= S_SWEEP;
                        end else begin
                            r_idx <= s_axis_tdata[KEY_BITS +: AW];
                            r_state <= S_FRD;
                        end
                    end
                end
                S_FRD: r_state <= S_FCMP;
                S_FCMP: begin
                    if (rdist != '0 && rhash == r_hash && rkey == r_key) begin
                        r_found <= 1'b1;
                        r_fidx <= r_idx;
                        r_fval <= rvalue;
                        r_state <= S_DECIDE;
                    end else if (rdist == '0 || r_n == CW'(BUCKETS - 1)) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_idx <= nxt;
                        r_n <= r_n + 1'b1;
                        r_state <= S_FRD;
                    end
                end
                S_DECIDE: begin
                    case (r_op)
                        REQ_GET: begin
                            r_state <= S_DONE;
                            if (r_found) begin
                                r_ostatus <= ST_FOUND;
                                r_ovalue <= r_fval;
                            end else begin
                                r_ostatus <= ST_NOT_FOUND;
                                r_ovalue <= '0;
                            end
                        end
                        REQ_SET: begin
                            if (r_found) begin
                                r_ostatus <= ST_REPLACED;
                                r_ovalue <= r_fval;
                                r_state <= S_DONE;
                            end else if (r_count >= lim_ext || r_count >= CW'(BUCKETS)) begin
                                r_ostatus <= ST_FULL;
                                r_ovalue <= '0;
                                r_state <= S_DONE;
                            end else begin
                                r_ostatus <= ST_INSERTED;
                                r_ovalue <= '0;
                                r_count <= r_count + 1'b1;
                                r_idx <= r_hash[AW-1:0];
                                r_val <= r_newval;
                                r_dist <= DW'(1);
                                r_state <= S_IRD;
                            end
                        end
                        REQ_DELETE: begin
                            if (r_found) begin
                                r_ostatus <= ST_DELETED;
                                r_ovalue <= r_fval;
                                r_count <= r_count - 1'b1;
                                r_hole <= r_fidx;
                                r_idx <= r_fidx + 1'b1;
                                r_n <= '0;
                                r_state <= S_DRD;
                            end else begin
                                r_ostatus <= ST_NOT_FOUND;
                                r_ovalue <= '0;
                                r_state <= S_DONE;
                            end
                        end
                        default: begin
                            r_ostatus <= ST_NOT_FOUND;
                            r_ovalue <= '0;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_IRD: r_state <= S_ICMP;
                S_ICMP: begin
                    if (rdist == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        if (rdist < r_dist) begin
                            r_hash <= rhash;
                            r_key <= rkey;
                            r_val <= rvalue;
                            r_dist <= rdist + 1'b1;
                        end else begin
                            r_dist <= r_dist + 1'b1;
                        end
                        r_idx <= nxt;
                        r_state <= S_IRD;
                    end
                end
                S_DRD: r_state <= S_DCMP;
                S_DCMP: begin
                    if (del_end) begin
                        r_state <= S_DONE;
                    end else begin
                        r_hole <= r_idx;
                        r_idx <= nxt;
                        r_n <= r_n + 1'b1;
                        r_state <= S_DRD;
                    end
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/rhht_checker.sv =====
// Port-level checks for the Robin Hood hash table unit, bound to the top level.
// Depends on robin_hood_hash_table_unit's ports only.
module rhht_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [2:0] status
);
    a_no_accept_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a word was taken");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> status <= 3'd5) else $error("bad status");
endmodule

bind robin_hood_hash_table_unit rhht_checker u_rhht_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .status(m_axis_tdata[2:0])
);

// ===== tb/robin_hood_hash_table_unit_test.sv =====
// Self-checking testbench for the Robin Hood hash table unit: directed table, limit tests,
// then random streams checked against a behavioral hash table model. Depends on rhht_pkg.
`timescale 1ns / 1ps

module robin_hood_hash_table_unit_test;
    import rhht_pkg::*;

    localparam int NB = 64;
    localparam int RAND_ITEMS = 1600;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam int LIMITS [4] = '{64, 48, 20, 127};

    typedef struct packed {
        t_req        op;
        logic [31:0] key;
        logic [31:0] hash;
        logic [31:0] value;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [31:0] value;
    } t_answer;

    typedef struct {
        t_request req;
        logic     chk;
        t_answer  ans;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    robin_hood_hash_table_unit dut (.*);

    always #6 i_clk = ~i_clk;

    // Model state of the table.
    logic [31:0] bkt_hash [NB];
    logic [31:0] bkt_key [NB];
    logic [31:0] bkt_val [NB];
    int          bkt_dist [NB];
    int          live_count;
    int          limit_reg;

    t_answer answers_due[$];
    int      errors = 0;
    longint  cycle_count = 0;
    int      long_stall = 0;
    bit      idle_free = 0;
    logic [31:0] key_pool[$];

    function automatic int find_bucket(logic [31:0] h, logic [31:0] k);
        int i;
        i = h % NB;
        for (int n = 0; n < NB; n++) begin
            if (bkt_dist[i] == 0) return -1;
            if (bkt_hash[i] == h && bkt_key[i] == k) return i;
            i = (i + 1) % NB;
        end
        return -1;
    endfunction

    function automatic t_answer hash_table_apply(t_request r);
        t_answer a;
        int s, i, d, j, td;
        logic [31:0] h, k, v, th, tk, tv;
        a.status = ST_NOT_FOUND;
        a.value = '0;
        if (r.op == REQ_CLEAR) begin
            for (int b = 0; b < NB; b++) bkt_dist[b] = 0;
            live_count = 0;
            a.status = ST_DELETED;
            return a;
        end
        s = find_bucket(r.hash, r.key);
        if (r.op == REQ_GET) begin
            if (s >= 0) begin
                a.status = ST_FOUND;
                a.value = bkt_val[s];
            end
        end else if (r.op == REQ_SET) begin
            if (s >= 0) begin
                a.status = ST_REPLACED;
                a.value = bkt_val[s];
                bkt_val[s] = r.value;
            end else if (live_count >= limit_reg || live_count >= NB) begin
                a.status = ST_FULL;
            end else begin
                h = r.hash; k = r.key; v = r.value; d = 1; i = h % NB;
                for (int n = 0; n < NB; n++) begin
                    if (bkt_dist[i] == 0) begin
                        bkt_hash[i] = h; bkt_key[i] = k; bkt_val[i] = v; bkt_dist[i] = d;
                        break;
                    end
                    if (bkt_dist[i] < d) begin
                        th = bkt_hash[i]; tk = bkt_key[i]; tv = bkt_val[i]; td = bkt_dist[i];
                        bkt_hash[i] = h; bkt_key[i] = k; bkt_val[i] = v; bkt_dist[i] = d;
                        h = th; k = tk; v = tv; d = td;
                    end
                    i = (i + 1) % NB;
                    d++;
                end
                live_count++;
                a.status = ST_INSERTED;
            end
        end else if (s >= 0) begin
            a.status = ST_DELETED;
            a.value = bkt_val[s];
            i = s;
            // Backward shift until an empty bucket or an entry at its home bucket.
            for (int n = 0; n + 1 < NB; n++) begin
                j = (i + 1) % NB;
                if (bkt_dist[j] <= 1) break;
                bkt_hash[i] = bkt_hash[j]; bkt_key[i] = bkt_key[j];
                bkt_val[i] = bkt_val[j]; bkt_dist[i] = bkt_dist[j] - 1;
                i = j;
            end
            bkt_dist[i] = 0;
            if (live_count > 0) live_count--;
        end
        return a;
    endfunction

    // The word stays offered after acceptance until the next request or a drain.
    task automatic send_request(t_request r, logic chk, t_answer typed);
        t_answer a;
        a = hash_table_apply(r);
        if (chk && a !== typed) begin
            $display("%0t directed row disagrees with model: expected %h model %h",
                     $time, typed, a);
            errors++;
        end
        answers_due.push_back(chk ? typed : a);
        while (!idle_free && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.value, r.hash, r.key};
        s_axis_tuser  <= r.op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_limit(int lim);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim[6:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_reg = lim;
    endtask

    function automatic t_request mk(t_req op, logic [31:0] k, logic [31:0] h, logic [31:0] v);
        t_request r;
        r.op = op; r.key = k; r.hash = h; r.value = v;
        return r;
    endfunction

    function automatic t_request rand_request(int nkeys, int hmask);
        t_request r;
        int p;
        p = $urandom_range(99);
        r.op = p < 45 ? REQ_SET : p < 72 ? REQ_GET : p < 99 ? REQ_DELETE : REQ_CLEAR;
        r.value = $urandom;
        if ($urandom_range(9) == 0) begin
            r.key = $urandom;
            r.hash = $urandom;
        end else begin
            r.key = key_pool[$urandom_range(nkeys - 1)];
            // Hash depends on key so equal keys share hashes; narrow masks force collisions.
            r.hash = (r.key * 32'h9E3779B1) & hmask | (r.key & ~hmask & 32'hFFFF_FFC0);
        end
        return r;
    endfunction

    // Receiver: random stalls, one long hold-off, checks every result word.
    always @(posedge i_clk) begin
        t_answer got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = t_status'(m_axis_tdata[2:0]);
                got.value = m_axis_tdata[34:3];
                if (answers_due.size() == 0) begin
                    $display("%0t unexpected result: actual %h", $time, got);
                    errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, want.status, got.status);
                        errors++;
                    end
                    if (got.value !== want.value) begin
                        $display("%0t value mismatch: expected %h actual %h",
                                 $time, want.value, got.value);
                        errors++;
                    end
                end
            end
            if (long_stall > 0) begin
                long_stall <= long_stall - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= idle_free || ($urandom_range(99) >= 34);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("robin_hood_hash_table_unit verification failed");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_row rw;
        int nkeys, hmask;
        for (int b = 0; b < NB; b++) bkt_dist[b] = 0;
        live_count = 0;
        limit_reg = 48;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: typed answers for the obvious rows.
        rw.chk = 1;
        rw.req = mk(REQ_GET, 32'h0, 32'h0, 32'h0);
        rw.ans = '{ST_NOT_FOUND, 32'h0}; rows.push_back(rw);
        rw.req = mk(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        rw.ans = '{ST_INSERTED, 32'h0}; rows.push_back(rw);
        rw.req = mk(REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        rw.ans = '{ST_FOUND, 32'hFFFF_FFFF}; rows.push_back(rw);
        rw.req = mk(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        rw.ans = '{ST_REPLACED, 32'hFFFF_FFFF}; rows.push_back(rw);
        rw.chk = 0;
        // Collisions on home bucket 63 wrap around the end of the table.
        for (int n = 0; n < 5; n++) begin
            rw.req = mk(REQ_SET, n, 32'h3F + (n << 6), 32'hA0 + n); rows.push_back(rw);
        end
        rw.req = mk(REQ_SET, 32'h77, 32'h0, 32'h55); rows.push_back(rw);
        rw.req = mk(REQ_GET, 32'h2, 32'hBF, 0); rows.push_back(rw);
        rw.req = mk(REQ_DELETE, 32'h1, 32'h7F, 0); rows.push_back(rw);
        rw.req = mk(REQ_GET, 32'h4, 32'h13F, 0); rows.push_back(rw);
        rw.req = mk(REQ_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0); rows.push_back(rw);
        rw.req = mk(REQ_GET, 32'h2, 32'h3F, 0); rows.push_back(rw);  // same key, other hash
        rw.chk = 1;
        rw.req = mk(REQ_DELETE, 32'h1234, 32'h5, 0);
        rw.ans = '{ST_NOT_FOUND, 32'h0}; rows.push_back(rw);
        rw.req = mk(REQ_CLEAR, 32'h0, 32'h0, 0);
        rw.ans = '{ST_DELETED, 32'h0}; rows.push_back(rw);
        rw.req = mk(REQ_GET, 32'h0, 32'h3F, 0);
        rw.ans = '{ST_NOT_FOUND, 32'h0}; rows.push_back(rw);
        foreach (rows[r]) send_request(rows[r].req, rows[r].chk, rows[r].ans);
        wait_drained();

        // Small limit: full refusals, and replace still allowed at the limit.
        write_limit(1);
        send_request(mk(REQ_SET, 32'h10, 32'h10, 32'h1), 1, '{ST_INSERTED, 32'h0});
        send_request(mk(REQ_SET, 32'h11, 32'h11, 32'h2), 1, '{ST_FULL, 32'h0});
        send_request(mk(REQ_SET, 32'h10, 32'h10, 32'h3), 1, '{ST_REPLACED, 32'h1});
        wait_drained();
        write_limit(0);
        send_request(mk(REQ_SET, 32'h12, 32'h12, 32'h2), 1, '{ST_FULL, 32'h0});
        wait_drained();
        // Limit above capacity: fill the free buckets, then two more.
        write_limit(127);
        for (int n = 0; n < 65; n++) send_request(mk(REQ_SET, n + 32'h100, n * 7, n), 0, '{ST_INSERTED, 0});
        wait_drained();

        // Random phases over several limits; a long receiver hold-off in the first.
        for (int ph = 0; ph < 4; ph++) begin
            write_limit(LIMITS[ph]);
            send_request(mk(REQ_CLEAR, $urandom, $urandom, $urandom), 0, '{ST_DELETED, 0});
            nkeys = ph == 2 ? 24 : 80;
            hmask = ph == 1 ? 32'h7 : 32'hFFFF_FFFF;
            key_pool.delete();
            for (int n = 0; n < nkeys; n++) key_pool.push_back($urandom);
            idle_free = (ph == 3);
            if (ph == 0) long_stall = 400;
            for (int n = 0; n < RAND_ITEMS / 4; n++) send_request(rand_request(nkeys, hmask),
                                                                  0, '{ST_INSERTED, 0});
            wait_drained();
        end
        idle_free = 0;

        if (errors == 0)
            $display("robin_hood_hash_table_unit verification clean");
        else
            $display("robin_hood_hash_table_unit verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/rhht_pkg.sv
sv/rhht_mem.sv
sv/robin_hood_hash_table_unit.sv
sv/rhht_checker.sv
tb/robin_hood_hash_table_unit_test.sv
